### hdl/rrp_pkg.sv
// Shared types, widths and codes of the request parser.
package rrp_pkg;

	// Field widths of the byte and result words
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned EVENT_W   = 3;
	localparam int unsigned ARG_W     = 10;

	// Configuration register widths and indexes
	localparam int unsigned MAX_COUNT_W  = 10;
	localparam int unsigned MAX_LENGTH_W = 20;
	localparam int unsigned CFG_DATA_W   = 20;
	localparam int unsigned CFG_INDEX_W  = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_COUNT  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 1'd1;

	localparam logic [MAX_COUNT_W-1:0]  MAX_COUNT_RST  = 10'd1023;
	localparam logic [MAX_LENGTH_W-1:0] MAX_LENGTH_RST = 20'd1048575;

	// Event codes of a result word
	localparam logic [EVENT_W-1:0] EV_HEADER  = 3'd0;
	localparam logic [EVENT_W-1:0] EV_DATA    = 3'd1;
	localparam logic [EVENT_W-1:0] EV_ARG_END = 3'd2;
	localparam logic [EVENT_W-1:0] EV_DONE    = 3'd3;
	localparam logic [EVENT_W-1:0] EV_ERROR   = 3'd4;

	// One result word
	typedef struct packed {
		logic [EVENT_W-1:0] event_res;
		logic [BYTE_W-1:0]  data_byte;
		logic [ARG_W-1:0]   arg_number;
		logic [ARG_W-1:0]   arg_total;
	} rrp_result_t;

endpackage

### hdl/rrp_cfg_regs.sv
// Limit registers written through the configuration port.
module rrp_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [rrp_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [rrp_pkg::CFG_DATA_W-1:0]      wr_data,
	output logic [rrp_pkg::MAX_COUNT_W-1:0]     max_arg_count,
	output logic [rrp_pkg::MAX_LENGTH_W-1:0]    max_arg_length
);
	import rrp_pkg::*;

	logic [MAX_COUNT_W-1:0]  max_count_q;
	logic [MAX_LENGTH_W-1:0] max_length_q;

	// Decode the index and load the addressed limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q  <= MAX_COUNT_RST;
			max_length_q <= MAX_LENGTH_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_COUNT:  max_count_q  <= wr_data[MAX_COUNT_W-1:0];
				REG_MAX_LENGTH: max_length_q <= wr_data[MAX_LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	assign max_arg_count  = max_count_q;
	assign max_arg_length = max_length_q;

endmodule

### hdl/rrp_core.sv
// Parser state registers and the per-byte next-state and event logic.
module rrp_core #(
	parameter int unsigned COUNT_BITS  = 10,
	parameter int unsigned LENGTH_BITS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [rrp_pkg::BYTE_W-1:0]        rx_byte_s1,
	input  logic [rrp_pkg::MAX_COUNT_W-1:0]   max_arg_count,
	input  logic [rrp_pkg::MAX_LENGTH_W-1:0]  max_arg_length,
	output rrp_pkg::rrp_result_t              res
);
	import rrp_pkg::*;

	// Accumulator holds a value up to the larger limit, times ten plus a digit
	localparam int unsigned NUM_BITS = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS;
	localparam int unsigned ACC_W    = NUM_BITS + 4;

	localparam logic [ACC_W-1:0] CNT_MASK = {{(ACC_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
	localparam logic [ACC_W-1:0] LEN_MASK = {{(ACC_W-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};

	// Phase codes
	localparam logic [3:0] PH_STAR        = 4'd0;
	localparam logic [3:0] PH_COUNT_FIRST = 4'd1;
	localparam logic [3:0] PH_COUNT_MORE  = 4'd2;
	localparam logic [3:0] PH_COUNT_LF    = 4'd3;
	localparam logic [3:0] PH_DOLLAR      = 4'd4;
	localparam logic [3:0] PH_LEN_FIRST   = 4'd5;
	localparam logic [3:0] PH_LEN_MORE    = 4'd6;
	localparam logic [3:0] PH_LEN_LF      = 4'd7;
	localparam logic [3:0] PH_DATA        = 4'd8;
	localparam logic [3:0] PH_DATA_CR     = 4'd9;
	localparam logic [3:0] PH_DATA_LF     = 4'd10;
	localparam logic [3:0] PH_SKIP        = 4'd11;

	// Framing characters
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

	logic [3:0]             phase_q,      phase_n;
	logic [ACC_W-1:0]       accum_q,      accum_n;
	logic [COUNT_BITS-1:0]  args_left_q,  args_left_n;
	logic [COUNT_BITS-1:0]  arg_index_q,  arg_index_n;
	logic [COUNT_BITS-1:0]  announced_q,  announced_n;
	logic [LENGTH_BITS-1:0] data_left_q,  data_left_n;

	logic                   is_digit;
	logic                   is_lf;
	logic [ACC_W-1:0]       accum_dig;
	logic [ACC_W-1:0]       cnt_limit;
	logic [ACC_W-1:0]       len_limit;
	logic [COUNT_BITS-1:0]  new_count;
	logic [COUNT_BITS-1:0]  args_dec;
	logic [LENGTH_BITS-1:0] new_length;
	logic [LENGTH_BITS-1:0] data_dec;
	logic                   err;
	logic [EVENT_W-1:0]     ev;
	logic [BYTE_W-1:0]      dbyte;
	logic [COUNT_BITS-1:0]  num;

	// Shared decimal step and limits
	assign is_digit   = (rx_byte_s1 >= CH_ZERO) && (rx_byte_s1 <= CH_NINE);
	assign is_lf      = (rx_byte_s1 == CH_LF);
	assign accum_dig  = (accum_q << 3) + (accum_q << 1) + {{(ACC_W-4){1'b0}}, rx_byte_s1[3:0]};
	assign cnt_limit  = ACC_W'(max_arg_count) & CNT_MASK;
	assign len_limit  = ACC_W'(max_arg_length) & LEN_MASK;
	assign new_count  = accum_q[COUNT_BITS-1:0];
	assign new_length = accum_q[LENGTH_BITS-1:0];
	assign args_dec   = args_left_q - 1'b1;
	assign data_dec   = data_left_q - 1'b1;

	// Next phase, counters and event for the byte in the input register
	always_comb begin
		phase_n     = phase_q;
		accum_n     = accum_q;
		args_left_n = args_left_q;
		arg_index_n = arg_index_q;
		announced_n = announced_q;
		data_left_n = data_left_q;
		err         = 1'b0;
		ev          = EV_HEADER;
		dbyte       = '0;
		num         = arg_index_q;

		case (phase_q)
			PH_STAR: begin
				if (rx_byte_s1 == CH_STAR) begin
					accum_n     = '0;
					announced_n = '0;
					phase_n     = PH_COUNT_FIRST;
				end else begin
					err = 1'b1;
				end
			end
			PH_COUNT_FIRST, PH_COUNT_MORE: begin
				if (is_digit) begin
					if (accum_dig <= cnt_limit) begin
						accum_n = accum_dig;
						phase_n = PH_COUNT_MORE;
					end else begin
						err = 1'b1;
					end
				end else if (rx_byte_s1 == CH_CR && phase_q == PH_COUNT_MORE) begin
					phase_n = PH_COUNT_LF;
				end else begin
					err = 1'b1;
				end
			end
			PH_COUNT_LF: begin
				if (is_lf) begin
					announced_n = new_count;
					args_left_n = new_count;
					arg_index_n = '0;
					num         = '0;
					accum_n     = '0;
					if (new_count == '0) begin
						ev      = EV_DONE;
						phase_n = PH_STAR;
					end else begin
						phase_n = PH_DOLLAR;
					end
				end else begin
					err = 1'b1;
				end
			end
			PH_DOLLAR: begin
				if (rx_byte_s1 == CH_DOLLAR) begin
					accum_n = '0;
					phase_n = PH_LEN_FIRST;
				end else begin
					err = 1'b1;
				end
			end
			PH_LEN_FIRST, PH_LEN_MORE: begin
				if (is_digit) begin
					if (accum_dig <= len_limit) begin
						accum_n = accum_dig;
						phase_n = PH_LEN_MORE;
					end else begin
						err = 1'b1;
					end
				end else if (rx_byte_s1 == CH_CR && phase_q == PH_LEN_MORE) begin
					phase_n = PH_LEN_LF;
				end else begin
					err = 1'b1;
				end
			end
			PH_LEN_LF: begin
				if (is_lf) begin
					data_left_n = new_length;
					accum_n     = '0;
					phase_n     = (new_length == '0) ? PH_DATA_CR : PH_DATA;
				end else begin
					err = 1'b1;
				end
			end
			PH_DATA: begin
				ev          = EV_DATA;
				dbyte       = rx_byte_s1;
				data_left_n = data_dec;
				if (data_dec == '0) begin
					phase_n = PH_DATA_CR;
				end
			end
			PH_DATA_CR: begin
				if (rx_byte_s1 == CH_CR) begin
					phase_n = PH_DATA_LF;
				end else begin
					err = 1'b1;
				end
			end
			PH_DATA_LF: begin
				if (is_lf) begin
					args_left_n = args_dec;
					if (args_dec == '0) begin
						ev      = EV_DONE;
						phase_n = PH_STAR;
					end else begin
						ev          = EV_ARG_END;
						arg_index_n = arg_index_q + 1'b1;
						phase_n     = PH_DOLLAR;
					end
				end else begin
					err = 1'b1;
				end
			end
			default: begin
				// Skip phase: drop up to and including the next LF
				phase_n = is_lf ? PH_STAR : PH_SKIP;
			end
		endcase

		// Error overrides the event and restarts framing
		if (err) begin
			ev      = EV_ERROR;
			dbyte   = '0;
			accum_n = '0;
			phase_n = is_lf ? PH_STAR : PH_SKIP;
		end
	end

	// Advance the parser state as the byte moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_STAR;
			accum_q     <= '0;
			args_left_q <= '0;
			arg_index_q <= '0;
			announced_q <= '0;
			data_left_q <= '0;
		end else if (step) begin
			phase_q     <= phase_n;
			accum_q     <= accum_n;
			args_left_q <= args_left_n;
			arg_index_q <= arg_index_n;
			announced_q <= announced_n;
			data_left_q <= data_left_n;
		end
	end

	assign res.event_res  = ev;
	assign res.data_byte  = dbyte;
	assign res.arg_number = ARG_W'(num);
	assign res.arg_total  = ARG_W'(announced_n);

endmodule

### hdl/resp_request_parser_unit.sv
// Top level of the request parser: byte and result registers, limits, parser core.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  rx_byte
//  out       output     out_valid/out_stall  event_res, data_byte, arg_number, arg_total
//  cfg       input      wr_en                wr_index, wr_data
//
// One byte per cycle sustained while out_stall is low; a taken byte goes to the input register,
// then its result word is loaded into the result register behind the combinational parser step.
// The parser state advances only when a byte moves into the result register.
// Reset clears the parser state, both valid flags and the limits to their maximum.
// A stall on the output holds the result word and backs up into in_stall.
module resp_request_parser_unit #(
	parameter int unsigned COUNT_BITS  = 10,
	parameter int unsigned LENGTH_BITS = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rrp_pkg::BYTE_W-1:0]           rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [rrp_pkg::EVENT_W-1:0]          event_res,
	output logic [rrp_pkg::BYTE_W-1:0]           data_byte,
	output logic [rrp_pkg::ARG_W-1:0]            arg_number,
	output logic [rrp_pkg::ARG_W-1:0]            arg_total,
	input  logic                                 wr_en,
	input  logic [rrp_pkg::CFG_INDEX_W-1:0]      wr_index,
	input  logic [rrp_pkg::CFG_DATA_W-1:0]       wr_data
);
	import rrp_pkg::*;

	logic                    valid_s1;
	logic [BYTE_W-1:0]       rx_byte_s1;
	logic                    valid_s2;
	rrp_result_t             result_s2;
	rrp_result_t             res;
	logic                    step;
	logic                    take;
	logic [MAX_COUNT_W-1:0]  max_arg_count;
	logic [MAX_LENGTH_W-1:0] max_arg_length;

	rrp_cfg_regs u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.max_arg_count  (max_arg_count),
		.max_arg_length (max_arg_length)
	);

	rrp_core #(
		.COUNT_BITS  (COUNT_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.rx_byte_s1     (rx_byte_s1),
		.max_arg_count  (max_arg_count),
		.max_arg_length (max_arg_length),
		.res            (res)
	);

	// Advance when a byte is held and the result register is empty or being drained
	assign step     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !step;
	assign take     = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign event_res  = result_s2.event_res;
	assign data_byte  = result_s2.data_byte;
	assign arg_number = result_s2.arg_number;
	assign arg_total  = result_s2.arg_total;

endmodule
